// File: rtl/core/frpq_pkg.sv
// Shared types, codes and constants of the filtered packet receive queue.
package frpq_pkg;

  // Default sizing of the queue.
  localparam int unsigned DEF_QUEUE_DEPTH      = 16;
  localparam int unsigned DEF_MAX_PACKET_BYTES = 512;

  // Stream and configuration widths.
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 152;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // Field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR4_W   = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned PLEN_W    = 10;
  localparam int unsigned QUEUED_W  = 5;
  localparam int unsigned COUNTER_W = 32;

  // Item kinds carried in tuser of the input side.
  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AGENT_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGENT_PORT    = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_READ      = 3'd0,
    STS_EMPTY     = 3'd1,
    STS_TOO_SMALL = 3'd2,
    STS_TAKEN     = 3'd3,
    STS_QUEUED    = 3'd4,
    STS_SOURCE    = 3'd5,
    STS_LARGE     = 3'd6,
    STS_FULL      = 3'd7
  } status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the accepted item
    logic fetch;    // read head slot length
    logic byte_rd;  // read head packet byte
    logic commit;   // update state, load result register
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_byte;  // item returns a stored byte
  } dp_sts_t;

endpackage

// File: rtl/core/frpq_ram.sv
// Generic simple dual-port RAM with registered read.
module frpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/frpq_ctrl.sv
// Item sequencer of the receive queue: handshakes and datapath commands.
module frpq_ctrl
  import frpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_BYTE  = 4'b1000
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  ctrl_cmd_t cmd;

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.need_byte) begin
          cmd.byte_rd = 1'b1;
          state_d     = S_BYTE;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_BYTE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;
  assign cmd_o     = cmd;

  // A result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_q || m_ready_i))
    else $error("commit while result register occupied");

  // A committed item shows up as a valid result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_valid_o)
    else $error("committed result not presented");

  // A captured item always goes to the slot length lookup.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> (state_q == S_FETCH))
    else $error("captured item skipped lookup");

endmodule

// File: rtl/core/frpq_dp.sv
// Datapath of the receive queue: filters, ring state, stores, counters, result register.
module frpq_dp
  import frpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_sts_t                sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  logic                   in_tuser_i,
  input  logic                   in_tlast_i,
  output logic [OUT_TDATA_W-1:0] out_tdata_o,
  output logic [OUT_TUSER_W-1:0] out_tuser_o,
  output logic                   out_tlast_o
);

  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LEN_W       = $clog2(MAX_PACKET_BYTES + 2);
  localparam int unsigned STORE_DEPTH = QUEUE_DEPTH * MAX_PACKET_BYTES;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [CNT_W-1:0]  QD_CNT    = CNT_W'(QUEUE_DEPTH);
  localparam logic [LEN_W-1:0]  MB_LEN    = LEN_W'(MAX_PACKET_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = (s == LAST_SLOT) ? '0 : s + 1'b1;
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [LEN_W-1:0]  off);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_PACKET_BYTES));
    return base + ADDR_W'(off);
  endfunction

  // Configuration
  logic [ADDR4_W-1:0] filt_addr_q;
  logic [PORT_W-1:0]  filt_port_q;

  // Captured item
  logic               action_q;
  logic [BYTE_W-1:0]  rx_byte_q;
  logic               rx_last_q;
  logic [ADDR4_W-1:0] src_addr_q;
  logic [PORT_W-1:0]  src_port_q;
  logic [LIMIT_W-1:0] limit_q;

  // Queue state
  logic [SLOT_W-1:0]    write_slot_q, write_slot_d;
  logic [SLOT_W-1:0]    read_slot_q, read_slot_d;
  logic [CNT_W-1:0]     pkt_cnt_q, pkt_cnt_d;
  logic [LEN_W-1:0]     inc_len_q, inc_len_d;
  logic                 inc_blk_q, inc_blk_d;
  logic [LEN_W-1:0]     read_off_q, read_off_d;
  logic                 rd_active_q, rd_active_d;
  logic [COUNTER_W-1:0] rx_total_q, rx_total_d;
  logic [COUNTER_W-1:0] full_drops_q, full_drops_d;
  logic [COUNTER_W-1:0] over_drops_q, over_drops_d;
  logic [COUNTER_W-1:0] src_drops_q, src_drops_d;

  // Result register
  logic [OUT_TDATA_W-1:0] out_tdata_q, out_tdata_d;
  status_e                out_status_q;
  logic                   out_last_q;

  // Memory ports
  logic [LEN_W-1:0]  slen_rdata;
  logic [BYTE_W-1:0] store_rdata;
  logic              slen_we, store_we;
  logic [ADDR_W-1:0] store_waddr, store_raddr;

  // Step logic
  status_e           status;
  logic [LEN_W-1:0]  plen;
  logic [BYTE_W-1:0] rd_byte;
  logic              rd_last, pop, need_byte;
  logic              rx_blocked, src_ok;
  logic [LEN_W-1:0]  rx_len, eff_len, rd_off;
  logic              rd_is_last, head_start, head_reject;

  always_comb begin
    write_slot_d = write_slot_q;
    read_slot_d  = read_slot_q;
    pkt_cnt_d    = pkt_cnt_q;
    inc_len_d    = inc_len_q;
    inc_blk_d    = inc_blk_q;
    read_off_d   = read_off_q;
    rd_active_d  = rd_active_q;
    rx_total_d   = rx_total_q;
    full_drops_d = full_drops_q;
    over_drops_d = over_drops_q;
    src_drops_d  = src_drops_q;
    status       = STS_EMPTY;
    plen         = '0;
    rd_byte      = '0;
    rd_last      = 1'b0;
    pop          = 1'b0;
    need_byte    = 1'b0;
    slen_we      = 1'b0;
    store_we     = 1'b0;

    // Receive side: fullness is judged at the first byte only.
    rx_blocked = (inc_len_q == '0) ? (pkt_cnt_q >= QD_CNT) : inc_blk_q;
    rx_len     = (inc_len_q <= MB_LEN) ? inc_len_q + 1'b1 : inc_len_q;
    src_ok     = (src_addr_q == filt_addr_q) && (src_port_q == filt_port_q);

    // Read side: zero length reads as one byte, offset clamps to the end.
    eff_len = (slen_rdata == '0) ? LEN_W'(1) :
              ((slen_rdata > MB_LEN) ? MB_LEN : slen_rdata);
    rd_off  = rd_active_q ? read_off_q : '0;
    if (rd_off >= eff_len) begin
      rd_off = eff_len - 1'b1;
    end
    rd_is_last  = (rd_off + 1'b1 >= eff_len);
    head_start  = !rd_active_q;
    head_reject = LIMIT_W'(slen_rdata) > limit_q;

    store_waddr = store_addr(write_slot_q, inc_len_q);
    store_raddr = store_addr(read_slot_q, rd_off);

    if (action_q == ACT_RECEIVE) begin
      store_we = !rx_blocked && (inc_len_q < MB_LEN);
      plen     = rx_len;
      if (!rx_last_q) begin
        status    = STS_TAKEN;
        inc_len_d = rx_len;
        inc_blk_d = rx_blocked;
      end else begin
        inc_len_d = '0;
        inc_blk_d = 1'b0;
        priority if (!src_ok) begin
          status      = STS_SOURCE;
          src_drops_d = src_drops_q + 1'b1;
        end else if (rx_len > MB_LEN) begin
          status       = STS_LARGE;
          over_drops_d = over_drops_q + 1'b1;
        end else if (rx_blocked) begin
          status       = STS_FULL;
          full_drops_d = full_drops_q + 1'b1;
        end else begin
          status       = STS_QUEUED;
          slen_we      = 1'b1;
          write_slot_d = next_slot(write_slot_q);
          pkt_cnt_d    = pkt_cnt_q + 1'b1;
          rx_total_d   = rx_total_q + 1'b1;
        end
      end
    end else begin
      priority if (head_start && (pkt_cnt_q == '0)) begin
        status = STS_EMPTY;
      end else if (head_start && head_reject) begin
        status = STS_TOO_SMALL;
        plen   = slen_rdata;
        pop    = 1'b1;
      end else begin
        need_byte = 1'b1;
        status    = STS_READ;
        plen      = eff_len;
        rd_byte   = store_rdata;
        rd_last   = rd_is_last;
        if (rd_is_last) begin
          pop = 1'b1;
        end else begin
          read_off_d  = rd_off + 1'b1;
          rd_active_d = 1'b1;
        end
      end
    end

    if (pop) begin
      read_slot_d = next_slot(read_slot_q);
      if (pkt_cnt_q != '0) begin
        pkt_cnt_d = pkt_cnt_q - 1'b1;
      end
      rd_active_d = 1'b0;
      read_off_d  = '0;
    end

    out_tdata_d = {1'b0, src_drops_d, over_drops_d, full_drops_d, rx_total_d,
                   QUEUED_W'(pkt_cnt_d), PLEN_W'(plen), rd_byte};
  end

  assign sts_o.need_byte = need_byte;

  frpq_ram #(
    .WIDTH (LEN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slot_len_ram (
    .clk_i   (clk_i),
    .we_i    (slen_we && cmd_i.commit),
    .waddr_i (write_slot_q),
    .wdata_i (rx_len),
    .re_i    (cmd_i.fetch),
    .raddr_i (read_slot_q),
    .rdata_o (slen_rdata)
  );

  frpq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_we && cmd_i.commit),
    .waddr_i (store_waddr),
    .wdata_i (rx_byte_q),
    .re_i    (cmd_i.byte_rd),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  // Item capture and result register: payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q   <= in_tuser_i;
      rx_last_q  <= in_tlast_i;
      rx_byte_q  <= in_tdata_i[7:0];
      src_addr_q <= in_tdata_i[39:8];
      src_port_q <= in_tdata_i[55:40];
      limit_q    <= in_tdata_i[71:56];
    end
    if (cmd_i.commit) begin
      out_tdata_q  <= out_tdata_d;
      out_status_q <= status;
      out_last_q   <= rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_addr_q  <= '0;
      filt_port_q  <= '0;
      write_slot_q <= '0;
      read_slot_q  <= '0;
      pkt_cnt_q    <= '0;
      inc_len_q    <= '0;
      inc_blk_q    <= 1'b0;
      read_off_q   <= '0;
      rd_active_q  <= 1'b0;
      rx_total_q   <= '0;
      full_drops_q <= '0;
      over_drops_q <= '0;
      src_drops_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_AGENT_ADDRESS) begin
          filt_addr_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_AGENT_PORT) begin
          filt_port_q <= cfg_data_i[PORT_W-1:0];
        end
      end
      if (cmd_i.commit) begin
        write_slot_q <= write_slot_d;
        read_slot_q  <= read_slot_d;
        pkt_cnt_q    <= pkt_cnt_d;
        inc_len_q    <= inc_len_d;
        inc_blk_q    <= inc_blk_d;
        read_off_q   <= read_off_d;
        rd_active_q  <= rd_active_d;
        rx_total_q   <= rx_total_d;
        full_drops_q <= full_drops_d;
        over_drops_q <= over_drops_d;
        src_drops_q  <= src_drops_d;
      end
    end
  end

  assign out_tdata_o = out_tdata_q;
  assign out_tuser_o = out_status_q;
  assign out_tlast_o = out_last_q;

  // The ring never holds more packets than slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_cnt_q <= QD_CNT)
    else $error("packet count beyond queue depth");

  // A read in progress always has a head packet behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_active_q |-> (pkt_cnt_q != '0))
    else $error("read in progress on empty queue");

  // Incoming length saturates one past the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_len_q <= MB_LEN + 1'b1)
    else $error("incoming length beyond saturation");

endmodule

// File: rtl/core/filtered_packet_receive_queue_unit.sv
// Top level of the filtered packet receive queue: sequencer plus datapath.
//
// Channel  Dir  Handshake               Payload
// s_axis   in   s_axis_tvalid/tready    tdata: rx_byte, source_address, source_port,
//                                       reader_limit; tuser: action; tlast: rx_last
// m_axis   out  m_axis_tvalid/tready    tdata: read_byte, packet_length, queued_packets,
//                                       received_total, full_drops, oversize_drops,
//                                       source_drops; tuser: status; tlast: read_last
// cfg      in   cfg_valid/cfg_ready     cfg_index (0 agent address, 1 agent port), cfg_data
//
// Steps: each item passes accept, slot length RAM lookup and decide/commit, plus a
//   packet store RAM read step when a byte is returned. A new item is accepted only
//   after the previous one has committed.
// Reset: asynchronous, active low; clears ring pointers, counts, read and receive
//   progress, drop counters and config. Packet store and slot lengths are not cleared.
// Stalls: a finished item waits in the result register; the next item is accepted
//   meanwhile and held at its commit step until the result register frees up.
// Config: cfg_ready is always high; writes are meant for idle periods only.
module filtered_packet_receive_queue_unit
  import frpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] rx_byte, [39:8] source_address, [55:40] source_port, [71:56] reader_limit
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  logic [0:0]             s_axis_tuser,
  input  logic                   s_axis_tlast,
  // Result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] read_byte, [17:8] packet_length, [22:18] queued_packets,
  // [54:23] received_total, [86:55] full_drops, [118:87] oversize_drops,
  // [150:119] source_drops, [151] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Config registers live in the datapath and are always writable.
  assign cfg_ready_o = 1'b1;

  frpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  frpq_dp #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser[0]),
    .in_tlast_i  (s_axis_tlast),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser),
    .out_tlast_o (m_axis_tlast)
  );

endmodule
